/* hdl/assert_macros.svh */
// Assertion macros used by the checker file bmp24_checker.sv.
// Stand-alone header, no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define ASSERT_CLKRST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Concurrent assertion on the block clock clk_i and reset rst_ni.
`define ASSERT_DEF(label, prop, msg) \
  `ASSERT_CLKRST(label, clk_i, rst_ni, prop, msg)

`endif

/* hdl/bmp24_pkg.sv */
// Types, codes and constants of the 24-bit BMP stream decoder.
// No dependencies; used by the interfaces and all decoder modules.
package bmp24_pkg;

  localparam int MAX_DIM = 4096;
  localparam int DIM_W   = 13;
  localparam int POS_W   = 12;
  localparam int HPOS_W  = 6;

  typedef logic [7:0]        byte_t;
  typedef logic [DIM_W-1:0]  dim_t;
  typedef logic [POS_W-1:0]  pos_t;
  typedef logic [HPOS_W-1:0] hpos_t;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_PIXEL  = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NOT_BMP   = 2'd0,
    ERR_NOT_24    = 2'd1,
    ERR_TOO_LARGE = 2'd2
  } err_e;

  localparam byte_t SIG_B     = 8'h42;
  localparam byte_t SIG_M     = 8'h4D;
  localparam logic [15:0] DEPTH_24 = 16'd24;

  localparam hpos_t POS_SIG_END    = 6'd1;
  localparam hpos_t POS_WIDTH_END  = 6'd21;
  localparam hpos_t POS_HEIGHT_END = 6'd25;
  localparam hpos_t POS_DEPTH_END  = 6'd29;
  localparam hpos_t POS_HDR_LAST   = 6'd53;

  localparam dim_t DIM_MAX      = DIM_W'(MAX_DIM);
  localparam dim_t DIM_TOO_BIG  = DIM_W'(MAX_DIM + 1);

  typedef struct packed {
    byte_t file_byte;
    logic  file_start;
  } item_t;

  typedef struct packed {
    kind_e kind;
    err_e  error_code;
    byte_t red;
    byte_t green;
    byte_t blue;
    pos_t  column;
    pos_t  row;
    dim_t  image_width;
    dim_t  image_height;
    logic  last;
  } result_t;

  function automatic dim_t clamp_dim(logic [31:0] v);
    return (v > 32'(MAX_DIM)) ? DIM_TOO_BIG : v[DIM_W-1:0];
  endfunction

endpackage

/* hdl/bmp24_if.sv */
// Valid/ready channels of the decoder: file bytes in, results out.
// Depends on bmp24_pkg.
interface bmp24_byte_if;
  import bmp24_pkg::*;
  logic  valid;
  logic  ready;
  byte_t file_byte;
  logic  file_start;
  modport source (output valid, file_byte, file_start, input ready);
  modport sink   (input valid, file_byte, file_start, output ready);
endinterface

interface bmp24_result_if;
  import bmp24_pkg::*;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [1:0]  error_code;
  byte_t       red;
  byte_t       green;
  byte_t       blue;
  pos_t        column;
  pos_t        row;
  dim_t        image_width;
  dim_t        image_height;
  logic        last;
  modport source (output valid, kind, error_code, red, green, blue, column, row,
                  image_width, image_height, last, input ready);
  modport sink   (input valid, kind, error_code, red, green, blue, column, row,
                  image_width, image_height, last, output ready);
endinterface

/* hdl/bmp24_in_stage.sv */
// Input register of the decoder: captures one file byte per cycle while take_i frees it.
// Depends on bmp24_pkg and bmp24_byte_if.
module bmp24_in_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  bmp24_byte_if.sink         byte_i,
  input  logic               take_i,
  output logic               valid_o,
  output bmp24_pkg::item_t   item_o
);
  import bmp24_pkg::*;

  logic  valid_q;
  item_t item_q;
  logic  load;

  assign byte_i.ready = !valid_q || take_i;
  assign load         = byte_i.valid && byte_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (take_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q.file_byte  <= byte_i.file_byte;
      item_q.file_start <= byte_i.file_start;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

/* hdl/bmp24_parser.sv */
// Header and pixel parser: parse state, header fields and pixel assembly.
// Depends on bmp24_pkg.
module bmp24_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                take_i,
  input  bmp24_pkg::item_t    item_i,
  output logic                res_valid_o,
  output bmp24_pkg::result_t  res_o
);
  import bmp24_pkg::*;

  localparam logic [1:0] PHASE_HEADER = 2'd0;
  localparam logic [1:0] PHASE_PIXEL  = 2'd1;
  localparam logic [1:0] PHASE_DONE   = 2'd2;

  logic [1:0]  phase_q, phase, phase_d;
  hpos_t       hpos_q, hpos, hpos_d;
  logic [31:0] shift_q, shift, shift_d, shift_new;
  dim_t        width_q, width, width_d;
  dim_t        height_q, height, height_d;
  pos_t        col_q, col, col_d;
  pos_t        row_q, row, row_d;
  logic [1:0]  bip_q, bip, bip_d;
  byte_t       blue_q, blue, blue_d;
  byte_t       green_q, green, green_d;
  logic [1:0]  pad_q, pad, pad_d;
  dim_t        col_inc, row_inc;
  logic        empty;
  logic        res_valid;
  result_t     res;

  always_comb begin
    phase  = item_i.file_start ? PHASE_HEADER : phase_q;
    hpos   = item_i.file_start ? '0 : hpos_q;
    shift  = item_i.file_start ? '0 : shift_q;
    width  = item_i.file_start ? '0 : width_q;
    height = item_i.file_start ? '0 : height_q;
    col    = item_i.file_start ? '0 : col_q;
    row    = item_i.file_start ? '0 : row_q;
    bip    = item_i.file_start ? '0 : bip_q;
    blue   = item_i.file_start ? '0 : blue_q;
    green  = item_i.file_start ? '0 : green_q;
    pad    = item_i.file_start ? '0 : pad_q;

    phase_d  = phase;
    hpos_d   = hpos;
    shift_d  = shift;
    width_d  = width;
    height_d = height;
    col_d    = col;
    row_d    = row;
    bip_d    = bip;
    blue_d   = blue;
    green_d  = green;
    pad_d    = pad;

    shift_new = {item_i.file_byte, shift[31:8]};
    col_inc   = {1'b0, col} + DIM_W'(1);
    row_inc   = {1'b0, row} + DIM_W'(1);
    empty     = (width == '0) || (height == '0);
    res_valid = 1'b0;
    res       = '0;

    case (phase)
      PHASE_HEADER: begin
        shift_d = shift_new;
        hpos_d  = hpos + HPOS_W'(1);
        case (hpos)
          POS_SIG_END: begin
            if (shift_new[23:16] != SIG_B || shift_new[31:24] != SIG_M) begin
              phase_d        = PHASE_DONE;
              res_valid      = 1'b1;
              res.kind       = KIND_ERROR;
              res.error_code = ERR_NOT_BMP;
              res.last       = 1'b1;
            end
          end
          POS_WIDTH_END: begin
            width_d = clamp_dim(shift_new);
          end
          POS_HEIGHT_END: begin
            height_d = clamp_dim(shift_new);
          end
          POS_DEPTH_END: begin
            if (shift_new[31:16] != DEPTH_24) begin
              phase_d        = PHASE_DONE;
              res_valid      = 1'b1;
              res.kind       = KIND_ERROR;
              res.error_code = ERR_NOT_24;
              res.last       = 1'b1;
            end else if (width > DIM_MAX || height > DIM_MAX) begin
              phase_d        = PHASE_DONE;
              res_valid      = 1'b1;
              res.kind       = KIND_ERROR;
              res.error_code = ERR_TOO_LARGE;
              res.last       = 1'b1;
            end
          end
          POS_HDR_LAST: begin
            phase_d          = empty ? PHASE_DONE : PHASE_PIXEL;
            res_valid        = 1'b1;
            res.kind         = KIND_HEADER;
            res.image_width  = width;
            res.image_height = height;
            res.last         = empty;
          end
          default: ;
        endcase
      end
      PHASE_PIXEL: begin
        if (pad != 2'd0) begin
          pad_d = pad - 2'd1;
        end else begin
          case (bip)
            2'd0: begin
              blue_d = item_i.file_byte;
              bip_d  = 2'd1;
            end
            2'd1: begin
              green_d = item_i.file_byte;
              bip_d   = 2'd2;
            end
            default: begin
              bip_d            = 2'd0;
              res_valid        = 1'b1;
              res.kind         = KIND_PIXEL;
              res.red          = item_i.file_byte;
              res.green        = green;
              res.blue         = blue;
              res.column       = col;
              res.row          = row;
              res.image_width  = width;
              res.image_height = height;
              if (col_inc >= width) begin
                col_d = '0;
                if (row_inc >= height) begin
                  res.last = 1'b1;
                  phase_d  = PHASE_DONE;
                end else begin
                  row_d = row_inc[POS_W-1:0];
                  pad_d = width[1:0];
                end
              end else begin
                col_d = col_inc[POS_W-1:0];
              end
            end
          endcase
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PHASE_HEADER;
      hpos_q   <= '0;
      shift_q  <= '0;
      width_q  <= '0;
      height_q <= '0;
      col_q    <= '0;
      row_q    <= '0;
      bip_q    <= '0;
      blue_q   <= '0;
      green_q  <= '0;
      pad_q    <= '0;
    end else if (take_i) begin
      phase_q  <= phase_d;
      hpos_q   <= hpos_d;
      shift_q  <= shift_d;
      width_q  <= width_d;
      height_q <= height_d;
      col_q    <= col_d;
      row_q    <= row_d;
      bip_q    <= bip_d;
      blue_q   <= blue_d;
      green_q  <= green_d;
      pad_q    <= pad_d;
    end
  end

  assign res_valid_o = res_valid;
  assign res_o       = res;

endmodule

/* hdl/bmp24_out_stage.sv */
// Result register of the decoder, driving the result channel.
// Depends on bmp24_pkg and bmp24_result_if.
module bmp24_out_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  bmp24_pkg::result_t  res_i,
  output logic                free_o,
  bmp24_result_if.source      result_o
);
  import bmp24_pkg::*;

  logic    valid_q;
  result_t res_q;

  assign free_o = !valid_q || result_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (result_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign result_o.valid        = valid_q;
  assign result_o.kind         = res_q.kind;
  assign result_o.error_code   = res_q.error_code;
  assign result_o.red          = res_q.red;
  assign result_o.green        = res_q.green;
  assign result_o.blue         = res_q.blue;
  assign result_o.column       = res_q.column;
  assign result_o.row          = res_q.row;
  assign result_o.image_width  = res_q.image_width;
  assign result_o.image_height = res_q.image_height;
  assign result_o.last         = res_q.last;

endmodule

/* hdl/bmp24_stream_decoder_unit.sv */
// Decoder for uncompressed 24-bit BMP files, one file byte per item in and
// header, pixel or error results out. Takes one byte every cycle while the
// result side keeps up; an accepted byte is held in the input register until
// the parser takes it and writes any result into the result register,
// and the result register reloads in the same cycle its waiting result is taken.
// Raise file_start on the first byte of each file; bytes after the final
// result of a file are dropped until the next file_start. No clearing pass
// after reset. Depends on bmp24_pkg, bmp24_if and the three stage modules.
module bmp24_stream_decoder_unit (
  input  logic            clk_i,
  input  logic            rst_ni,
  bmp24_byte_if.sink      byte_i,
  bmp24_result_if.source  result_o
);
  import bmp24_pkg::*;

  logic    in_valid;
  item_t   in_item;
  logic    out_free;
  logic    take;
  logic    res_valid;
  result_t res;

  assign take = in_valid && out_free;

  bmp24_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .byte_i  (byte_i),
    .take_i  (take),
    .valid_o (in_valid),
    .item_o  (in_item)
  );

  bmp24_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .item_i      (in_item),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  bmp24_out_stage u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (take && res_valid),
    .res_i    (res),
    .free_o   (out_free),
    .result_o (result_o)
  );

endmodule

/* hdl/bmp24_checker.sv */
// Port-level checks of the decoder result channel, bound to the top level.
// Depends on bmp24_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bmp24_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               valid_i,
  input logic               ready_i,
  input logic [1:0]         kind_i,
  input logic [1:0]         error_code_i,
  input bmp24_pkg::pos_t    column_i,
  input bmp24_pkg::pos_t    row_i,
  input bmp24_pkg::dim_t    image_width_i,
  input bmp24_pkg::dim_t    image_height_i,
  input logic               last_i
);
  import bmp24_pkg::*;

  `ASSERT_DEF(a_valid_holds, valid_i && !ready_i |=> valid_i, "result dropped while stalled")
  `ASSERT_DEF(a_error_last, valid_i && kind_i == KIND_ERROR |-> last_i, "error not last")
  `ASSERT_DEF(a_code_clear, valid_i && kind_i != KIND_ERROR |-> error_code_i == ERR_NOT_BMP, "stray error code")
  `ASSERT_DEF(a_col_range, valid_i && kind_i == KIND_PIXEL |-> {1'b0, column_i} < image_width_i, "column out of range")
  `ASSERT_DEF(a_row_range, valid_i && kind_i == KIND_PIXEL |-> {1'b0, row_i} < image_height_i, "row out of range")

endmodule

bind bmp24_stream_decoder_unit bmp24_checker u_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .valid_i        (result_o.valid),
  .ready_i        (result_o.ready),
  .kind_i         (result_o.kind),
  .error_code_i   (result_o.error_code),
  .column_i       (result_o.column),
  .row_i          (result_o.row),
  .image_width_i  (result_o.image_width),
  .image_height_i (result_o.image_height),
  .last_i         (result_o.last)
);
